@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; compiled out under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

@@ src/sgnq_pkg.sv @@
// ----------------------------------------------------------------------------
// sgnq_pkg
// Shared constants and types of the grid neighbor query block.
// ----------------------------------------------------------------------------
`default_nettype none
package sgnq_pkg;
   localparam int MAX_TRACKS = 64;
   localparam int IDX_W = $clog2(MAX_TRACKS);
   localparam int CNT_W = $clog2(MAX_TRACKS + 1);
   localparam logic [30:0] BIN_LEN_RESET = 31'd50000;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_QUERY  = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      KIND_INSERTED = 3'd0,
      KIND_FULL     = 3'd1,
      KIND_CLEARED  = 3'd2,
      KIND_MATCH    = 3'd3,
      KIND_NONE     = 3'd4
   } kind_type;

   typedef struct packed {
      logic [31:0]        ident;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [23:0] vel_x;
      logic signed [23:0] vel_y;
      logic signed [23:0] vel_z;
      logic [47:0]        update_time;
   } rec_type;

   typedef struct packed {
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic signed [31:0] cz;
   } cell_type;

   typedef struct packed {
      op_type   op;
      rec_type  rec;
      cell_type grid;
   } cmd_type;

   localparam int REC_W  = $bits(rec_type);
   localparam int CELL_W = $bits(cell_type);
endpackage
`default_nettype wire

@@ src/spatial_grid_neighbor_query_top.sv @@
// ----------------------------------------------------------------------------
// spatial_grid_neighbor_query_top
// Uniform grid track store with 27-cell neighbor query.
//
//   channel  ports                  flow
//   req      start/busy, req_*      command in, taken when start & !busy
//   rsp      rsp_valid, rsp_*       one beat per cycle, no back-pressure
//   csr      csr_we, csr_wdata      cell edge write, registered
//
// Insert/query hold busy for three passes on one shared 32-step divider and
// the push into the queue, which waits while it is full; clear only for the
// push. Query scans the store once per neighbor cell, last beat via the drain
// and finish states; insert/clear give one beat. A two-entry queue decouples
// binning from execution; busy covers binning and queue push, not execution.
// Synchronous active-high reset; store contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module spatial_grid_neighbor_query_top
   import sgnq_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_opcode,
   input  wire logic [31:0]        req_ident,
   input  wire logic signed [31:0] req_pos_x,
   input  wire logic signed [31:0] req_pos_y,
   input  wire logic signed [31:0] req_pos_z,
   input  wire logic signed [23:0] req_vel_x,
   input  wire logic signed [23:0] req_vel_y,
   input  wire logic signed [23:0] req_vel_z,
   input  wire logic [47:0]        req_update_time,
   output logic                    rsp_valid,
   output logic [2:0]              rsp_kind,
   output logic [31:0]             rsp_out_ident,
   output logic signed [31:0]      rsp_out_pos_x,
   output logic signed [31:0]      rsp_out_pos_y,
   output logic signed [31:0]      rsp_out_pos_z,
   output logic signed [23:0]      rsp_out_vel_x,
   output logic signed [23:0]      rsp_out_vel_y,
   output logic signed [23:0]      rsp_out_vel_z,
   output logic [47:0]             rsp_out_time,
   output logic                    rsp_last,
   input  wire logic               csr_we,
   input  wire logic [30:0]        csr_wdata
);
   logic [30:0] bin_len_ff;
   cmd_type     req_cmd;
   cmd_type     q_cmd;
   logic        q_valid, q_pop;
   kind_type    kind;
   rec_type     orec;

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_len_ff <= BIN_LEN_RESET;
      end else if (csr_we) begin
         bin_len_ff <= csr_wdata;
      end
   end

   always_comb begin
      req_cmd                 = '0;
      req_cmd.op              = op_type'(req_opcode);
      req_cmd.rec.ident       = req_ident;
      req_cmd.rec.pos_x       = req_pos_x;
      req_cmd.rec.pos_y       = req_pos_y;
      req_cmd.rec.pos_z       = req_pos_z;
      req_cmd.rec.vel_x       = req_vel_x;
      req_cmd.rec.vel_y       = req_vel_y;
      req_cmd.rec.vel_z       = req_vel_z;
      req_cmd.rec.update_time = req_update_time;
   end

   sgnq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_cmd   (req_cmd),
      .bin_len   (bin_len_ff),
      .busy      (busy),
      .q_valid   (q_valid),
      .q_cmd     (q_cmd),
      .q_pop     (q_pop)
   );

   sgnq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_cmd     (q_cmd),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_kind  (kind),
      .rsp_rec   (orec),
      .rsp_last  (rsp_last)
   );

   assign rsp_kind      = kind;
   assign rsp_out_ident = orec.ident;
   assign rsp_out_pos_x = orec.pos_x;
   assign rsp_out_pos_y = orec.pos_y;
   assign rsp_out_pos_z = orec.pos_z;
   assign rsp_out_vel_x = orec.vel_x;
   assign rsp_out_vel_y = orec.vel_y;
   assign rsp_out_vel_z = orec.vel_z;
   assign rsp_out_time  = orec.update_time;
endmodule
`default_nettype wire

@@ src/sgnq_ram.sv @@
// ----------------------------------------------------------------------------
// sgnq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module sgnq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule
`default_nettype wire

@@ src/sgnq_div.sv @@
// ----------------------------------------------------------------------------
// sgnq_div
// Radix-2 restoring floor divider: signed 32-bit position by cell size.
// ----------------------------------------------------------------------------
`default_nettype none
module sgnq_div
   import sgnq_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [31:0] dividend,
   input  wire logic [30:0]        divisor,
   output logic                    done,
   output logic signed [31:0]      quotient
);
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [30:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [30:0] dvs_ff, dvs_in;
   logic        neg_ff, neg_in;
   logic [31:0] trial, diff;
   logic        ge;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      trial   = {rem_ff, quo_ff[31]};
      diff    = trial - {1'b0, dvs_ff};
      ge      = trial >= {1'b0, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         neg_in  = dividend[31];
         quo_in  = dividend[31] ? 32'(-dividend) : 32'(dividend);
         dvs_in  = (divisor == '0) ? 31'd1 : divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[30:0] : trial[30:0];
         quo_in = {quo_ff[30:0], ge};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   // floor for negatives: -q, or -q-1 = ~q when there is a remainder
   always_comb begin
      if (!neg_ff) begin
         quotient = $signed(quo_ff);
      end else if (rem_ff != '0) begin
         quotient = $signed(~quo_ff);
      end else begin
         quotient = $signed(-quo_ff);
      end
   end

   assign done = done_ff;
endmodule
`default_nettype wire

@@ src/sgnq_front.sv @@
// ----------------------------------------------------------------------------
// sgnq_front
// Accepts commands, bins positions into grid cells, queues them for the back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module sgnq_front
   import sgnq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire cmd_type     req_cmd,
   input  wire logic [30:0] bin_len,
   output logic             busy,
   output logic             q_valid,
   output cmd_type          q_cmd,
   input  wire logic        q_pop
);
   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_DIV  = 3'b010,
      F_PUSH = 3'b100
   } fstate_type;

   fstate_type         state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [1:0]         axis_ff, axis_in;
   logic               dstart_ff, dstart_in;
   cmd_type            fifo_ff [2];
   logic               wr_ff, rd_ff;
   logic [1:0]         fcnt_ff;
   logic               push, pop;
   logic               div_done;
   logic signed [31:0] div_q;
   logic signed [31:0] dividend;

   always_comb begin
      case (axis_ff)
         2'd0:    dividend = cmd_ff.rec.pos_x;
         2'd1:    dividend = cmd_ff.rec.pos_y;
         default: dividend = cmd_ff.rec.pos_z;
      endcase
   end

   sgnq_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (dstart_ff),
      .dividend (dividend),
      .divisor  (bin_len),
      .done     (div_done),
      .quotient (div_q)
   );

   assign push = (state_ff == F_PUSH) && (fcnt_ff != 2'd2);
   assign pop  = q_pop && (fcnt_ff != 2'd0);

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      axis_in   = axis_ff;
      dstart_in = 1'b0;
      case (state_ff)
         F_IDLE: begin
            if (start) begin
               cmd_in  = req_cmd;
               axis_in = 2'd0;
               case (req_cmd.op)
                  OP_INSERT, OP_QUERY: begin
                     state_in  = F_DIV;
                     dstart_in = 1'b1;
                  end
                  OP_CLEAR: state_in = F_PUSH;
                  default:  state_in = F_IDLE;
               endcase
            end
         end
         F_DIV: begin
            if (div_done) begin
               case (axis_ff)
                  2'd0:    cmd_in.grid.cx = div_q;
                  2'd1:    cmd_in.grid.cy = div_q;
                  default: cmd_in.grid.cz = div_q;
               endcase
               if (axis_ff == 2'd2) begin
                  state_in = F_PUSH;
               end else begin
                  axis_in   = axis_ff + 2'd1;
                  dstart_in = 1'b1;
               end
            end
         end
         F_PUSH: begin
            if (push) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= F_IDLE;
         dstart_ff <= 1'b0;
         wr_ff     <= 1'b0;
         rd_ff     <= 1'b0;
         fcnt_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         dstart_ff <= dstart_in;
         if (push) begin
            wr_ff <= ~wr_ff;
         end
         if (pop) begin
            rd_ff <= ~rd_ff;
         end
         fcnt_ff <= fcnt_ff + {1'b0, push} - {1'b0, pop};
      end
      cmd_ff  <= cmd_in;
      axis_ff <= axis_in;
      if (push) begin
         fifo_ff[wr_ff] <= cmd_ff;
      end
   end

   assign busy    = (state_ff != F_IDLE);
   assign q_valid = (fcnt_ff != 2'd0);
   assign q_cmd   = fifo_ff[rd_ff];

   `ASSERT_NEVER(a_fifo_over, clock, reset, fcnt_ff == 2'd3, "queue count overflow")
   `ASSERT_PROP(a_div_in_div, clock, reset, div_done |-> state_ff == F_DIV, "stray div done")
endmodule
`default_nettype wire

@@ src/sgnq_back.sv @@
// ----------------------------------------------------------------------------
// sgnq_back
// Executes queued commands: store writes, clear, 27-cell neighbor scan.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module sgnq_back
   import sgnq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_valid,
   input  wire cmd_type q_cmd,
   output logic         q_pop,
   output logic         rsp_valid,
   output kind_type     rsp_kind,
   output rec_type      rsp_rec,
   output logic         rsp_last
);
   typedef enum logic [3:0] {
      B_IDLE  = 4'b0001,
      B_SCAN  = 4'b0010,
      B_DRAIN = 4'b0100,
      B_FIN   = 4'b1000
   } bstate_type;

   bstate_type       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [1:0]       dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in;
   cell_type         center_ff, center_in;
   logic             s1_valid_ff, s1_valid_in;
   logic [5:0]       s1_off_ff, s1_off_in;
   logic             pend_ff, pend_in;
   rec_type          prec_ff, prec_in;
   logic             ov_ff, ov_in;
   kind_type         okind_ff, okind_in;
   rec_type          orec_ff, orec_in;
   logic             olast_ff, olast_in;
   logic             we;
   rec_type          rec_rd;
   cell_type         cell_rd;
   logic             match;
   logic             row_end;

   sgnq_ram #(.WIDTH(REC_W), .DEPTH(MAX_TRACKS)) u_rec_ram (
      .clock (clock),
      .we    (we),
      .waddr (count_ff[IDX_W-1:0]),
      .wdata (q_cmd.rec),
      .raddr (idx_ff),
      .rdata (rec_rd)
   );

   sgnq_ram #(.WIDTH(CELL_W), .DEPTH(MAX_TRACKS)) u_cell_ram (
      .clock (clock),
      .we    (we),
      .waddr (count_ff[IDX_W-1:0]),
      .wdata (q_cmd.grid),
      .raddr (idx_ff),
      .rdata (cell_rd)
   );

   // neighbor index c + off - 1, in 34 bits so edge cells never wrap
   function automatic logic axis_hit(logic signed [31:0] c, logic signed [31:0] s,
                                     logic [1:0] off);
      logic signed [33:0] tgt;
      tgt = 34'(c) + $signed({32'd0, off}) - 34'sd1;
      return 34'(s) == tgt;
   endfunction

   assign match = s1_valid_ff
                  && axis_hit(center_ff.cx, cell_rd.cx, s1_off_ff[5:4])
                  && axis_hit(center_ff.cy, cell_rd.cy, s1_off_ff[3:2])
                  && axis_hit(center_ff.cz, cell_rd.cz, s1_off_ff[1:0]);
   assign row_end = ({1'b0, idx_ff} == count_ff - CNT_W'(1));
   assign q_pop = (state_ff == B_IDLE) && q_valid;
   assign we    = q_pop && (q_cmd.op == OP_INSERT) && (count_ff != CNT_W'(MAX_TRACKS));

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      dx_in       = dx_ff;
      dy_in       = dy_ff;
      dz_in       = dz_ff;
      center_in   = center_ff;
      s1_valid_in = 1'b0;
      s1_off_in   = {dx_ff, dy_ff, dz_ff};
      pend_in     = pend_ff;
      prec_in     = prec_ff;
      ov_in       = 1'b0;
      okind_in    = okind_ff;
      orec_in     = '0;
      olast_in    = 1'b1;

      // compare stage: hold one match back so the final one can carry last
      if (match) begin
         if (pend_ff) begin
            ov_in    = 1'b1;
            okind_in = KIND_MATCH;
            orec_in  = prec_ff;
            olast_in = 1'b0;
         end
         pend_in = 1'b1;
         prec_in = rec_rd;
      end

      case (state_ff)
         B_IDLE: begin
            if (q_pop) begin
               case (q_cmd.op)
                  OP_INSERT: begin
                     ov_in = 1'b1;
                     if (we) begin
                        okind_in = KIND_INSERTED;
                        count_in = count_ff + CNT_W'(1);
                     end else begin
                        okind_in = KIND_FULL;
                     end
                  end
                  OP_CLEAR: begin
                     ov_in    = 1'b1;
                     okind_in = KIND_CLEARED;
                     count_in = '0;
                  end
                  OP_QUERY: begin
                     if (count_ff == '0) begin
                        ov_in    = 1'b1;
                        okind_in = KIND_NONE;
                     end else begin
                        state_in  = B_SCAN;
                        center_in = q_cmd.grid;
                        idx_in    = '0;
                        dx_in     = 2'd0;
                        dy_in     = 2'd0;
                        dz_in     = 2'd0;
                        pend_in   = 1'b0;
                     end
                  end
                  default: state_in = B_IDLE;
               endcase
            end
         end
         B_SCAN: begin
            s1_valid_in = 1'b1;
            if (row_end) begin
               idx_in = '0;
               if (dz_ff != 2'd2) begin
                  dz_in = dz_ff + 2'd1;
               end else begin
                  dz_in = 2'd0;
                  if (dy_ff != 2'd2) begin
                     dy_in = dy_ff + 2'd1;
                  end else begin
                     dy_in = 2'd0;
                     if (dx_ff != 2'd2) begin
                        dx_in = dx_ff + 2'd1;
                     end else begin
                        state_in = B_DRAIN;
                     end
                  end
               end
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         B_DRAIN: state_in = B_FIN;
         B_FIN: begin
            state_in = B_IDLE;
            ov_in    = 1'b1;
            olast_in = 1'b1;
            if (pend_ff) begin
               okind_in = KIND_MATCH;
               orec_in  = prec_ff;
            end else begin
               okind_in = KIND_NONE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= B_IDLE;
         count_ff    <= '0;
         s1_valid_ff <= 1'b0;
         pend_ff     <= 1'b0;
         ov_ff       <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         s1_valid_ff <= s1_valid_in;
         pend_ff     <= pend_in;
         ov_ff       <= ov_in;
      end
      idx_ff    <= idx_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      dz_ff     <= dz_in;
      center_ff <= center_in;
      s1_off_ff <= s1_off_in;
      prec_ff   <= prec_in;
      okind_ff  <= okind_in;
      orec_ff   <= orec_in;
      olast_ff  <= olast_in;
   end

   assign rsp_valid = ov_ff;
   assign rsp_kind  = okind_ff;
   assign rsp_rec   = orec_ff;
   assign rsp_last  = olast_ff;

   `ASSERT_NEVER(a_count_max, clock, reset, count_ff > CNT_W'(MAX_TRACKS), "count overflow")
   `ASSERT_PROP(a_last_single, clock, reset, (ov_ff && okind_ff != KIND_MATCH) |-> olast_ff, "no last")
   `ASSERT_PROP(a_match_scan, clock, reset, match |-> (state_ff == B_SCAN || state_ff == B_DRAIN), "stray hit")
endmodule
`default_nettype wire

@@ sim/tb_spatial_grid_neighbor_query_top.sv @@
// ----------------------------------------------------------------------------
// tb_spatial_grid_neighbor_query_top
// Self-checking bench for the grid neighbor query block: a directed table,
// then random insert/query/clear traffic under several cell sizes, with a
// scoreboard fed by a local model of the grid store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_spatial_grid_neighbor_query_top;
   import sgnq_pkg::*;

   typedef struct {
      op_type             op;
      logic [31:0]        id;
      logic signed [31:0] x, y, z;
      logic signed [23:0] vx, vy, vz;
      logic [47:0]        t;
      bit                 typed;
      kind_type           kind;
   } cmd_row;

   typedef struct packed {
      kind_type kind;
      rec_type  rec;
      logic     last;
   } beat_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_opcode = '0;
   logic [31:0]        req_ident = '0;
   logic signed [31:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic signed [23:0] req_vel_x = '0, req_vel_y = '0, req_vel_z = '0;
   logic [47:0]        req_update_time = '0;
   logic               rsp_valid;
   logic [2:0]         rsp_kind;
   logic [31:0]        rsp_out_ident;
   logic signed [31:0] rsp_out_pos_x, rsp_out_pos_y, rsp_out_pos_z;
   logic signed [23:0] rsp_out_vel_x, rsp_out_vel_y, rsp_out_vel_z;
   logic [47:0]        rsp_out_time;
   logic               rsp_last;
   logic               csr_we = 1'b0;
   logic [30:0]        csr_wdata = '0;

   localparam int SETTLE = 2000;
   localparam int WDOG_LIMIT = 60000;

   spatial_grid_neighbor_query_top DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_ident(req_ident),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_pos_z(req_pos_z),
      .req_vel_x(req_vel_x), .req_vel_y(req_vel_y), .req_vel_z(req_vel_z),
      .req_update_time(req_update_time),
      .rsp_valid(rsp_valid), .rsp_kind(rsp_kind), .rsp_out_ident(rsp_out_ident),
      .rsp_out_pos_x(rsp_out_pos_x), .rsp_out_pos_y(rsp_out_pos_y),
      .rsp_out_pos_z(rsp_out_pos_z), .rsp_out_vel_x(rsp_out_vel_x),
      .rsp_out_vel_y(rsp_out_vel_y), .rsp_out_vel_z(rsp_out_vel_z),
      .rsp_out_time(rsp_out_time), .rsp_last(rsp_last),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // grid store model
   logic [30:0] model_bin_len;
   int          grid_count;
   rec_type     grid_rec [MAX_TRACKS];
   longint      grid_cx [MAX_TRACKS];
   longint      grid_cy [MAX_TRACKS];
   longint      grid_cz [MAX_TRACKS];

   beat_type pending_beats [$];
   int       mismatches = 0;
   int       beats_seen = 0;
   int       match_beats = 0;
   int       full_beats = 0;
   int       items_sent = 0;
   int       idle_cycles = 0;
   bit       gaps_on = 1'b1;

   function automatic longint grid_bin(logic signed [31:0] p);
      longint pv;
      longint c;
      longint q;
      pv = p;
      c = (model_bin_len == 0) ? 1 : longint'(model_bin_len);
      q = pv / c;
      if ((pv % c) != 0 && pv < 0) q = q - 1;
      return q;
   endfunction

   function automatic beat_type empty_beat(kind_type k);
      beat_type b;
      b.kind = k;
      b.rec = '0;
      b.last = 1'b1;
      return b;
   endfunction

   // Updates the store model and queues the beats the command must produce.
   task automatic apply_cmd(cmd_row r);
      rec_type  rc;
      beat_type b;
      longint   gx, gy, gz;
      int       found;
      beat_type hits [$];
      rc = '{r.id, r.x, r.y, r.z, r.vx, r.vy, r.vz, r.t};
      case (r.op)
         OP_INSERT: begin
            if (grid_count >= MAX_TRACKS) begin
               hits = {hits, empty_beat(KIND_FULL)};
            end else begin
               grid_rec[grid_count] = rc;
               grid_cx[grid_count] = grid_bin(r.x);
               grid_cy[grid_count] = grid_bin(r.y);
               grid_cz[grid_count] = grid_bin(r.z);
               grid_count++;
               hits = {hits, empty_beat(KIND_INSERTED)};
            end
         end
         OP_CLEAR: begin
            grid_count = 0;
            hits = {hits, empty_beat(KIND_CLEARED)};
         end
         OP_QUERY: begin
            gx = grid_bin(r.x);
            gy = grid_bin(r.y);
            gz = grid_bin(r.z);
            found = 0;
            for (int dx = -1; dx <= 1; dx++)
               for (int dy = -1; dy <= 1; dy++)
                  for (int dz = -1; dz <= 1; dz++)
                     for (int i = 0; i < grid_count; i++)
                        if (grid_cx[i] == gx + dx && grid_cy[i] == gy + dy &&
                            grid_cz[i] == gz + dz && found < MAX_TRACKS) begin
                           b.kind = KIND_MATCH;
                           b.rec = grid_rec[i];
                           b.last = 1'b0;
                           hits = {hits, b};
                           found++;
                        end
            if (found == 0) hits = {hits, empty_beat(KIND_NONE)};
            else hits[found-1].last = 1'b1;
         end
         default: ;
      endcase
      // directed rows with a typed-in answer override the model's beat
      if (r.typed) hits = '{empty_beat(r.kind)};
      foreach (hits[i]) pending_beats = {pending_beats, hits[i]};
   endtask

   // scoreboard
   always @(posedge clock) begin
      beat_type got;
      beat_type want;
      if (!reset && rsp_valid) begin
         got.kind = kind_type'(rsp_kind);
         got.rec = '{rsp_out_ident, rsp_out_pos_x, rsp_out_pos_y, rsp_out_pos_z,
                     rsp_out_vel_x, rsp_out_vel_y, rsp_out_vel_z, rsp_out_time};
         got.last = rsp_last;
         beats_seen++;
         if (pending_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR %0t: unexpected beat kind=%0d id=%h", $realtime,
                        rsp_kind, rsp_out_ident);
         end else begin
            want = pending_beats.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("ERROR %0t: beat mismatch", $realtime);
                  $display("  exp kind=%0d last=%0d id=%h pos=%0d,%0d,%0d vel=%0d,%0d,%0d t=%h",
                           want.kind, want.last, want.rec.ident, want.rec.pos_x,
                           want.rec.pos_y, want.rec.pos_z, want.rec.vel_x,
                           want.rec.vel_y, want.rec.vel_z, want.rec.update_time);
                  $display("  got kind=%0d last=%0d id=%h pos=%0d,%0d,%0d vel=%0d,%0d,%0d t=%h",
                           got.kind, got.last, got.rec.ident, got.rec.pos_x,
                           got.rec.pos_y, got.rec.pos_z, got.rec.vel_x,
                           got.rec.vel_y, got.rec.vel_z, got.rec.update_time);
               end
            end
            if (want.kind == KIND_MATCH) match_beats++;
            if (want.kind == KIND_FULL) full_beats++;
         end
      end
   end

   // watchdog: cycles with no handshake of any kind
   always @(posedge clock) begin
      if (reset || rsp_valid || csr_we || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic send_cmd(cmd_row r);
      req_opcode <= r.op;
      req_ident <= r.id;
      req_pos_x <= r.x;
      req_pos_y <= r.y;
      req_pos_z <= r.z;
      req_vel_x <= r.vx;
      req_vel_y <= r.vy;
      req_vel_z <= r.vz;
      req_update_time <= r.t;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      apply_cmd(r);
      items_sent++;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   // stop sending, let every queued beat arrive, then cover any silent work
   task automatic drain_all();
      start <= 1'b0;
      @(posedge clock);
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_bin_len(logic [30:0] v);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      model_bin_len = v;
      @(posedge clock);
   endtask

   function automatic cmd_row mk(op_type op, logic [31:0] id, longint x, longint y,
                                 longint z, int vx, int vy, int vz, logic [47:0] t,
                                 bit typed, kind_type k);
      cmd_row r;
      r = '{op, id, 32'(x), 32'(y), 32'(z), 24'(vx), 24'(vy), 24'(vz), t, typed, k};
      return r;
   endfunction

   function automatic longint rand_near(longint base, longint c);
      longint span;
      longint v;
      span = 3 * c;
      if (span > 64'sd2147483648) span = 64'sd2147483648;
      v = base + longint'({$urandom, $urandom} % (2 * span + 1)) - span;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v;
   endfunction

   function automatic cmd_row rand_cmd(longint bx, longint by, longint bz, bit inserts_only);
      cmd_row r;
      int     pick;
      longint c;
      c = (model_bin_len == 0) ? 1 : longint'(model_bin_len);
      pick = inserts_only ? 0 : $urandom_range(0, 99);
      r.op = (pick < 58) ? OP_INSERT : (pick < 94) ? OP_QUERY : (pick < 97) ? OP_CLEAR : OP_NONE;
      r.id = $urandom;
      if ($urandom_range(0, 9) < 2) begin
         r.x = $urandom;
         r.y = $urandom;
         r.z = $urandom;
      end else begin
         r.x = 32'(rand_near(bx, c));
         r.y = 32'(rand_near(by, c));
         r.z = 32'(rand_near(bz, c));
      end
      r.vx = 24'($urandom);
      r.vy = 24'($urandom);
      r.vz = 24'($urandom);
      r.t = 48'({$urandom, $urandom});
      r.typed = 1'b0;
      r.kind = KIND_NONE;
      return r;
   endfunction

   initial begin
      cmd_row      directed [$];
      logic [30:0] sizes [7];
      longint      bx, by, bz;
      int          phase_items;

      model_bin_len = BIN_LEN_RESET;
      grid_count = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table at the reset cell size
      directed = {directed, mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 1, KIND_NONE)};
      directed = {directed, mk(OP_INSERT, 0, 0, 0, 0, 0, 0, 0, 0, 1, KIND_INSERTED)};
      directed = {directed, mk(OP_INSERT, 32'hFFFF_FFFF, 2147483647, 2147483647,
                               2147483647, 8388607, 8388607, 8388607,
                               48'hFFFF_FFFF_FFFF, 1, KIND_INSERTED)};
      directed = {directed, mk(OP_INSERT, 1, -2147483648, -2147483648, -2147483648,
                               -8388608, -8388608, -8388608, 1, 1, KIND_INSERTED)};
      directed = {directed, mk(OP_INSERT, 2, -1, -1, -1, -1, 1, -8388608,
                               48'h8000_0000_0001, 0, KIND_NONE)};
      directed = {directed, mk(OP_INSERT, 3, 49999, 50000, -50000, 5, -5, 0, 77, 0,
                               KIND_NONE)};
      directed = {directed, mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0, KIND_NONE)};
      directed = {directed, mk(OP_QUERY, 0, 2147483647, 2147483647, 2147483647, 0, 0, 0,
                               0, 0, KIND_NONE)};
      directed = {directed, mk(OP_QUERY, 0, -2147483648, -2147483648, -2147483648, 0, 0,
                               0, 0, 0, KIND_NONE)};
      directed = {directed, mk(OP_QUERY, 0, -50001, 50001, -99999, 0, 0, 0, 0, 0,
                               KIND_NONE)};
      directed = {directed, mk(OP_NONE, 9, 1, 2, 3, 4, 5, 6, 7, 0, KIND_NONE)};
      directed = {directed, mk(OP_INSERT, 5, 10, 20, 30, 100, 200, 300, 400, 0,
                               KIND_NONE)};
      directed = {directed, mk(OP_QUERY, 0, 1, 1, 1, 0, 0, 0, 0, 0, KIND_NONE)};
      directed = {directed, mk(OP_QUERY, 0, 2147433648, 2147483647, 2147483647, 0, 0, 0,
                               0, 0, KIND_NONE)};
      directed = {directed, mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 1, KIND_CLEARED)};
      directed = {directed, mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 1, KIND_NONE)};
      directed = {directed, mk(OP_QUERY, 0, 2147483647, 2147483647, 2147483647, 0, 0, 0,
                               0, 1, KIND_NONE)};
      foreach (directed[i]) send_cmd(directed[i]);
      drain_all();

      // zero size acts as one; both ends of the range; one size picked at random
      sizes = '{31'd0, 31'd1, 31'h7FFF_FFFF, 31'd3, 31'd1000, BIN_LEN_RESET,
                31'($urandom_range(1, 200000))};
      foreach (sizes[p]) begin
         write_bin_len(sizes[p]);
         gaps_on = (p != 6);
         bx = longint'($signed($urandom));
         by = longint'($signed($urandom));
         bz = longint'($signed($urandom));
         if (p == 2) bx = 64'sd2147483647;
         phase_items = 38;
         // one phase fills the store past capacity in a tight cluster
         if (p == 3) begin
            send_cmd(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, KIND_NONE));
            repeat (68) send_cmd(rand_cmd(bx, by, bz, 1'b1));
         end
         repeat (phase_items) send_cmd(rand_cmd(bx, by, bz, 1'b0));
         drain_all();
      end

      if (pending_beats.size() != 0) mismatches++;
      $display("Sent %0d commands over 8 cell-size settings; checked %0d beats", items_sent,
               beats_seen);
      $display("  including %0d neighbor matches and %0d rejected inserts", match_beats,
               full_beats);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

@@ files.f @@
+incdir+src
src/sgnq_pkg.sv
src/sgnq_ram.sv
src/sgnq_div.sv
src/sgnq_front.sv
src/sgnq_back.sv
src/spatial_grid_neighbor_query_top.sv
sim/tb_spatial_grid_neighbor_query_top.sv
